### hdl/ndsf_pkg.sv
// ----------------------------------------------------------------------------
// ndsf_pkg
// Shared types, sizes and helpers for the near-duplicate segment filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ndsf_pkg;

  // table and coordinate sizing
  localparam int TABLE_DEPTH = 64;
  localparam int COORD_BITS  = 12;
  localparam int FIELD_BITS  = 12;
  localparam int THR_BITS    = 12;
  localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_BITS    = (COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(10);

  typedef logic [COORD_BITS-1:0] coord_t;

  // one stored segment, start endpoint in the upper half
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } seg_t;

  localparam int SEG_BITS = $bits(seg_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // low coordinate bits of a port field, zero-extended when the table is wider
  function automatic coord_t to_coord(input logic [FIELD_BITS-1:0] f);
    logic [FIELD_BITS+COORD_BITS-1:0] w;
    w = {{COORD_BITS{1'b0}}, f};
    return w[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/near_duplicate_segment_filter.sv
// ----------------------------------------------------------------------------
// near_duplicate_segment_filter
// Drops segments that lie close to one already seen in the current frame.
// ----------------------------------------------------------------------------
//
//  channel   signals                                       transfer when
//  -------   -------------------------------------------   ----------------
//  input     start_x start_y end_x end_y frame_start ...   start && !busy
//  result    out_start_x .. out_frame_end kept overflow    done (one cycle)
//  config    cfg_data                                      cfg_write
//
//  An item walks the stored entries through the table RAM, one read a cycle;
//  the walk reads all count stored entries (count is at most TABLE_DEPTH =
//  64) and is followed by the drain and finish states, with done registered
//  from finish; an empty table or a frame start skips the walk.
//  A new item can be taken in the same cycle the previous result is shown.
//  Reset clears the entry count and loads the threshold; the table itself is
//  not cleared, since only entries below the count are ever read.
//  The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module near_duplicate_segment_filter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ndsf_pkg::FIELD_BITS-1:0]     start_x,
  input  wire logic [ndsf_pkg::FIELD_BITS-1:0]     start_y,
  input  wire logic [ndsf_pkg::FIELD_BITS-1:0]     end_x,
  input  wire logic [ndsf_pkg::FIELD_BITS-1:0]     end_y,
  input  wire logic                                frame_start,
  input  wire logic                                frame_end,
  input  wire logic                                cfg_write,
  input  wire logic [ndsf_pkg::THR_BITS-1:0]       cfg_data,
  output logic                                     done,
  output logic      [ndsf_pkg::FIELD_BITS-1:0]     out_start_x,
  output logic      [ndsf_pkg::FIELD_BITS-1:0]     out_start_y,
  output logic      [ndsf_pkg::FIELD_BITS-1:0]     out_end_x,
  output logic      [ndsf_pkg::FIELD_BITS-1:0]     out_end_y,
  output logic                                     kept,
  output logic                                     overflow,
  output logic                                     out_frame_end
);
  import ndsf_pkg::*;

  state_t                state, state_next;
  logic [ADDR_BITS-1:0]  idx;
  logic [CNT_BITS-1:0]   cnt;
  logic                  dup;
  logic                  rvalid;
  logic [THR_BITS-1:0]   thr;
  logic [FIELD_BITS-1:0] in_sx, in_sy, in_ex, in_ey;
  logic                  in_fe;

  logic                  accept;
  logic                  last;
  logic                  full;
  logic                  ram_re, ram_we;
  logic [ADDR_BITS-1:0]  waddr;
  seg_t                  cur, entry;
  logic                  hit;

  assign accept = start && !busy;
  assign last   = (CNT_BITS'(idx) + CNT_BITS'(1)) == cnt;
  assign full   = cnt == CNT_BITS'(TABLE_DEPTH);
  assign waddr  = cnt[ADDR_BITS-1:0];

  // current segment in table coordinates
  always_comb begin
    cur.sx = to_coord(in_sx);
    cur.sy = to_coord(in_sy);
    cur.ex = to_coord(in_ex);
    cur.ey = to_coord(in_ey);
  end

  ndsf_ram #(
    .WIDTH (SEG_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (cur),
    .re    (ram_re),
    .raddr (idx),
    .rdata (entry)
  );

  ndsf_match u_match (
    .cur   (cur),
    .entry (entry),
    .thr   (thr),
    .hit   (hit)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (frame_start || cnt == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy   = 1'b1;
    ram_re = 1'b0;
    ram_we = 1'b0;
    case (state)
      ST_IDLE:   busy   = 1'b0;
      ST_SCAN:   ram_re = 1'b1;
      ST_DRAIN:  ram_re = 1'b0;
      ST_FINISH: ram_we = !dup && !full;
      default:   busy   = 1'b0;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      rvalid <= 1'b0;
      dup    <= 1'b0;
      thr    <= THR_RESET;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= ram_re;
      done   <= state == ST_FINISH;
      if (cfg_write) begin
        thr <= cfg_data;
      end
      if (accept) begin
        dup <= 1'b0;
        if (frame_start) begin
          cnt <= '0;
        end
      end else if (rvalid && hit) begin
        dup <= 1'b1;
      end
      if (ram_we) begin
        cnt <= cnt + CNT_BITS'(1);
      end
    end
  end

  // input latch and scan address
  always_ff @(posedge clk) begin
    if (accept) begin
      in_sx <= start_x;
      in_sy <= start_y;
      in_ex <= end_x;
      in_ey <= end_y;
      in_fe <= frame_end;
      idx   <= '0;
    end else if (ram_re) begin
      idx <= idx + ADDR_BITS'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      out_start_x   <= in_sx;
      out_start_y   <= in_sy;
      out_end_x     <= in_ex;
      out_end_y     <= in_ey;
      out_frame_end <= in_fe;
      kept          <= !dup;
      overflow      <= !dup && full;
    end
  end

endmodule

`default_nettype wire

### hdl/ndsf_ram.sv
// ----------------------------------------------------------------------------
// ndsf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ndsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/ndsf_match.sv
// ----------------------------------------------------------------------------
// ndsf_match
// Endpoint-to-endpoint closeness test of a segment against one table entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ndsf_match (
  input  wire ndsf_pkg::seg_t                cur,
  input  wire ndsf_pkg::seg_t                entry,
  input  wire logic [ndsf_pkg::THR_BITS-1:0] thr,
  output logic                               hit
);
  import ndsf_pkg::*;

  logic [3:0] close;

  // absolute difference of one coordinate below the threshold
  function automatic logic near(input coord_t a, input coord_t b,
                                input logic [THR_BITS-1:0] t);
    coord_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return CMP_BITS'(d) < CMP_BITS'(t);
  endfunction

  // all four coordinates must be close
  always_comb begin
    close[3] = near(cur.sx, entry.sx, thr);
    close[2] = near(cur.sy, entry.sy, thr);
    close[1] = near(cur.ex, entry.ex, thr);
    close[0] = near(cur.ey, entry.ey, thr);
    hit      = &close;
  end

endmodule

`default_nettype wire

### hdl/ndsf_checker.sv
// ----------------------------------------------------------------------------
// ndsf_checker
// Port-level checks of the segment filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ndsf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic kept,
  input wire logic overflow
);

  // an accepted segment always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an input transfer");

  // a result is only shown once the block has finished its item
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // busy ends only with a result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("busy dropped without a result");

  // strobes never run back to back
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // overflow only on a kept segment
  a_ovf_kept: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> kept)
    else $error("overflow on a duplicate");

endmodule

bind near_duplicate_segment_filter ndsf_checker u_ndsf_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .kept     (kept),
  .overflow (overflow)
);

`default_nettype wire
